// ===== hw/rtl/weighted_choice_prefix_sum_core_macros.svh =====
// assertion macros used by the checker file
`ifndef WEIGHTED_CHOICE_PREFIX_SUM_CORE_MACROS_SVH
`define WEIGHTED_CHOICE_PREFIX_SUM_CORE_MACROS_SVH

// same-cycle implication
`define WCPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define WCPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/wcps_pkg.sv =====
// shared types, codes and widths of the weighted choice core
package wcps_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int KIND_W         = 2;
	localparam int ID_W           = 32;
	localparam int WEIGHT_W       = 24;
	localparam int VALUE_W        = 32;
	localparam int SUM_W          = 32;
	localparam int CHOSEN_INDEX_W = 8;
	localparam int STATUS_W       = 2;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 40;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic issue;
		logic step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic done;
		logic out_busy;
	} dp_sts_t;

endpackage

// ===== hw/rtl/wcps_ram.sv =====
// generic single-write, single-read ram with registered read data
module wcps_ram #(
	parameter int WIDTH = wcps_pkg::SUM_W,
	parameter int DEPTH = wcps_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/wcps_dp.sv =====
// datapath: table stores, running total, upper-bound search and result register
module wcps_dp #(
	parameter int TABLE_DEPTH = wcps_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wcps_pkg::dp_cmd_t              cmd,
	output wcps_pkg::dp_sts_t              sts,
	input  logic [wcps_pkg::IN_TDATA_W-1:0]  in_data,
	input  logic                           m_axis_tready,
	output logic                           m_axis_tvalid,
	output logic [wcps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [wcps_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import wcps_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [ID_W-1:0]     in_id;
	logic [WEIGHT_W-1:0] in_weight;
	logic [VALUE_W-1:0]  in_value;

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] total_q;
	logic [SUM_W-1:0] new_total;
	logic             full;

	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   lo_q, hi_q, mid_q;
	logic [CNT_W-1:0]   mid_cur, nlo, nhi, mid_next;
	logic               gt, done;
	logic [IDX_W-1:0]   idx_q, idx_next;
	logic               empty_q, beyond_q, beyond_next;

	logic             pre_re;
	logic [IDX_W-1:0] pre_raddr;
	logic [SUM_W-1:0] pre_rdata;
	logic [ID_W-1:0]  id_rdata;

	logic                  out_valid_q;
	logic [ID_W-1:0]       out_id_q;
	logic [CHOSEN_INDEX_W-1:0] out_idx_q;
	logic [STATUS_W-1:0]   out_status_q;

	assign in_id     = in_data[ID_W-1:0];
	assign in_weight = in_data[ID_W+WEIGHT_W-1:ID_W];
	assign in_value  = in_data[IN_TDATA_W-1:ID_W+WEIGHT_W];

	assign full      = (count_q >= CNT_W'(TABLE_DEPTH));
	assign new_total = total_q + SUM_W'(in_weight);

	// search step arithmetic
	assign mid_cur  = lo_q + ((hi_q - lo_q) >> 1);
	assign gt       = (pre_rdata > value_q);
	assign nlo      = gt ? lo_q : mid_q + CNT_W'(1);
	assign nhi      = gt ? mid_q : hi_q;
	assign mid_next = nlo + ((nhi - nlo) >> 1);
	assign done     = (nlo >= nhi);

	assign beyond_next = (nlo >= count_q);
	assign idx_next    = beyond_next ? IDX_W'(count_q - CNT_W'(1)) : nlo[IDX_W-1:0];

	assign pre_re    = cmd.issue || (cmd.step && !done);
	assign pre_raddr = cmd.issue ? mid_cur[IDX_W-1:0] : mid_next[IDX_W-1:0];

	wcps_ram #(
		.WIDTH(SUM_W),
		.DEPTH(TABLE_DEPTH)
	) u_prefix_ram (
		.clk  (clk),
		.we   (cmd.append && !full),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(new_total),
		.re   (pre_re),
		.raddr(pre_raddr),
		.rdata(pre_rdata)
	);

	wcps_ram #(
		.WIDTH(ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_id_ram (
		.clk  (clk),
		.we   (cmd.append && !full),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(in_id),
		.re   (cmd.step && done),
		.raddr(idx_next),
		.rdata(id_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.append && !full) begin
			count_q <= count_q + CNT_W'(1);
			total_q <= new_total;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			value_q <= in_value;
			lo_q    <= '0;
			hi_q    <= count_q;
			empty_q <= (count_q == '0);
		end
		if (cmd.issue) begin
			mid_q <= mid_cur;
		end
		if (cmd.step) begin
			lo_q <= nlo;
			hi_q <= nhi;
			if (done) begin
				idx_q    <= idx_next;
				beyond_q <= beyond_next;
			end else begin
				mid_q <= mid_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (empty_q) begin
				out_id_q     <= '0;
				out_idx_q    <= '0;
				out_status_q <= STATUS_EMPTY;
			end else begin
				out_id_q     <= id_rdata;
				out_idx_q    <= CHOSEN_INDEX_W'(idx_q);
				out_status_q <= beyond_q ? STATUS_BEYOND : STATUS_OK;
			end
		end
	end

	assign sts.empty    = (count_q == '0);
	assign sts.done     = done;
	assign sts.out_busy = out_valid_q && !m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_idx_q, out_id_q};
	assign m_axis_tuser  = out_status_q;

endmodule

// ===== hw/rtl/wcps_ctrl.sv =====
// controller: decodes input transfers and sequences the search
module wcps_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [wcps_pkg::KIND_W-1:0] kind,
	input  wcps_pkg::dp_sts_t           sts,
	output wcps_pkg::dp_cmd_t           cmd
);
	import wcps_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_FETCH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					unique case (kind)
						KIND_CLEAR:  cmd.clear = 1'b1;
						KIND_APPEND: cmd.append = 1'b1;
						KIND_DRAW: begin
							cmd.start = 1'b1;
							state_d   = sts.empty ? ST_FETCH : ST_ISSUE;
						end
						default: ;
					endcase
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_d   = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.step = 1'b1;
				if (sts.done) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/weighted_choice_prefix_sum_core.sv =====
// Weighted random choice over a loaded table of ids and prefix sums. Each input
// transfer carries a kind in tuser: clear empties the table, append stores an id
// and adds its weight to the running prefix sum (ignored when the table is full),
// draw takes a value already drawn in [0, total) and returns the first entry whose
// prefix sum exceeds it, with its index. A value at or above the total returns the
// last entry with status 1; a draw on an empty table returns zeros with status 2.
// Clear and append are taken in the idle state, which stays open for input. A draw
// passes through the issue, look and fetch states (an empty table goes straight to
// fetch), making one prefix-sum read per search step on the single prefix read port.
// A finished result waits in the output register while the next clear or append
// is accepted; a draw holds in its last cycle while an earlier result is stalled.
// The tables need no clearing pass after reset.
module weighted_choice_prefix_sum_core #(
	parameter int TABLE_DEPTH = wcps_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// entry_id, entry_weight, draw_value
	input  logic [wcps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [wcps_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// chosen_id, chosen_index
	output logic [wcps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic [wcps_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import wcps_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	wcps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.kind         (s_axis_tuser),
		.sts          (sts),
		.cmd          (cmd)
	);

	wcps_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_data      (s_axis_tdata),
		.m_axis_tready(m_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ===== hw/rtl/wcps_checker.sv =====
// port-level checker of the weighted choice core and its bind
`include "weighted_choice_prefix_sum_core_macros.svh"

module wcps_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [wcps_pkg::KIND_W-1:0]      s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [wcps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [wcps_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import wcps_pkg::*;

	logic draw_xfer;
	logic stalled;
	logic status_known;
	logic empty_out;

	assign draw_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_DRAW);
	assign stalled   = m_axis_tvalid && !m_axis_tready;
	assign status_known = (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_BEYOND)
		|| (m_axis_tuser == STATUS_EMPTY);
	assign empty_out = m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY);

	// a stalled result transfer holds
	`WCPS_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_axis_tvalid)
	`WCPS_ASSERT_NEXT(a_out_stable, clk, arst_n, stalled, $stable({m_axis_tuser, m_axis_tdata}))
	// a draw keeps the input closed while it searches
	`WCPS_ASSERT_NEXT(a_draw_busy, clk, arst_n, draw_xfer, !s_axis_tready)
	// only defined status codes leave the block
	`WCPS_ASSERT_IMPL(a_status_code, clk, arst_n, m_axis_tvalid, status_known)
	// empty-table result carries zero id and index
	`WCPS_ASSERT_IMPL(a_empty_zero, clk, arst_n, empty_out, m_axis_tdata == '0)

endmodule

bind weighted_choice_prefix_sum_core wcps_checker u_wcps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
